// ===== rtl/clw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_pkg - shared types and constants of the core liveness watchdog
// Item formats, per-core record layout, status and mode codes, and the
// saturating increment used by the counters.
// ----------------------------------------------------------------------------
package clw_pkg;

	// Item modes
	localparam logic [1:0] MODE_SAMPLE   = 2'd0;
	localparam logic [1:0] MODE_MANUAL   = 2'd1;
	localparam logic [1:0] MODE_POWER_ON = 2'd2;

	// Power-on outcomes
	localparam logic [1:0] PWR_SUCCESS    = 2'd0;
	localparam logic [1:0] PWR_ALREADY_ON = 2'd1;

	// Configuration register indexes
	localparam logic CFG_FREEZE_THRESHOLD = 1'b0;
	localparam logic CFG_ACTIVE_CORES     = 1'b1;

	// Configuration reset values
	localparam logic [7:0] THRESHOLD_RESET    = 8'd6;
	localparam logic [3:0] ACTIVE_CORES_RESET = 4'd4;

	localparam logic [7:0] RUN_MAX = 8'hFF;

	typedef enum logic [3:0] {
		ST_IGNORED   = 4'd0,
		ST_ALIVE     = 4'd1,
		ST_FROZEN    = 4'd2,
		ST_HALF      = 4'd3,
		ST_RECOVER   = 4'd4,
		ST_INVALID   = 4'd5,
		ST_RECOVERED = 4'd6,
		ST_WEDGE     = 4'd7,
		ST_FAILED    = 4'd8
	} status_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  core;
		logic [31:0] idle_count;
		logic [1:0]  power_code;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [2:0]  event_core;
		logic        power_on_request;
		logic        drain_request;
		logic        core_online;
		logic [7:0]  frozen_count;
		logic [31:0] attempt_total;
		logic [31:0] success_total;
		logic [31:0] warning_total;
	} out_item_t;

	// Per-core record held in the state memory
	typedef struct packed {
		logic [31:0] last_sample;
		logic        seeded;
		logic [7:0]  frozen_run;
		logic        online;
		logic        awaiting_power;
		logic [31:0] attempts;
		logic [31:0] successes;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		last_sample:    32'd0,
		seeded:         1'b0,
		frozen_run:     8'd0,
		online:         1'b1,
		awaiting_power: 1'b0,
		attempts:       32'd0,
		successes:      32'd0
	};

	typedef struct packed {
		logic [7:0] freeze_threshold;
		logic [3:0] active_cores;
	} cfg_t;

	// Context of the item under update
	typedef struct packed {
		in_item_t item;
		logic     in_range;
	} ctx_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage

// ===== rtl/core_liveness_watchdog.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// core_liveness_watchdog - per-core liveness watchdog
// Tracks idle-counter samples per secondary core, warns and starts
// recovery on stuck cores or on manual request, and books power-on responses.
// ----------------------------------------------------------------------------
// Each item goes through the update stage: the core's record comes out of the
// registered state memory, is updated and written back, and the result item is
// loaded into the output register once that register can take it. The input
// stalls while an item is being updated, so one item is in flight at a time.
// The output register lets a new item enter while the previous result
// still waits. Per-core records reset through valid flops, so there is no
// clearing pass after reset. Configuration is written through cfg_we /
// cfg_index / cfg_data and must only change while the block is idle.
module core_liveness_watchdog import clw_pkg::*; #(
	parameter int CORE_SLOTS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [7:0] cfg_data,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req_data,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp_data
);

	localparam int AW = $clog2(CORE_SLOTS);

	cfg_t                  cfg_q;
	logic [CORE_SLOTS-1:0] seen_q;
	logic [31:0]           warnings_q;
	logic                  busy_s1;
	ctx_t                  ctx_s1;
	logic                  seen_s1;
	logic                  rsp_valid_q;
	out_item_t             rsp_data_q;

	logic          accept;
	logic          done;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] addr_s1;
	logic          in_range;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t        entry;
	entry_t        entry_nxt;
	logic          write;
	logic [31:0]   warnings_nxt;
	out_item_t     result;

	assign accept   = req_valid && !req_stall;
	assign req_stall = busy_s1;
	assign done     = busy_s1 && (!rsp_valid_q || !rsp_stall);
	assign rd_addr  = AW'(32'(req_data.core));
	assign addr_s1  = AW'(32'(ctx_s1.item.core));
	assign in_range = (32'(req_data.core) < 32'(CORE_SLOTS));

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freeze_threshold <= THRESHOLD_RESET;
			cfg_q.active_cores     <= ACTIVE_CORES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FREEZE_THRESHOLD: cfg_q.freeze_threshold <= cfg_data;
				CFG_ACTIVE_CORES:     cfg_q.active_cores     <= cfg_data[3:0];
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	// State memory: one record per core slot
	clw_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (CORE_SLOTS)
	) u_state_ram (
		.clk   (clk),
		.we    (done && write),
		.waddr (addr_s1),
		.wdata (entry_nxt),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Records never written read as their reset value
	assign entry = seen_s1 ? entry_t'(ram_rdata) : ENTRY_RESET;

	clw_update u_update (
		.ctx          (ctx_s1),
		.cfg          (cfg_q),
		.entry        (entry),
		.warnings     (warnings_q),
		.entry_nxt    (entry_nxt),
		.write        (write),
		.warnings_nxt (warnings_nxt),
		.result       (result)
	);

	// Advance the item through the update stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
			seen_q      <= '0;
			warnings_q  <= 32'd0;
		end else begin
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
				warnings_q  <= warnings_nxt;
				if (write) begin
					seen_q[addr_s1] <= 1'b1;
				end
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture item context and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ctx_s1.item     <= req_data;
			ctx_s1.in_range <= in_range;
			seen_s1         <= in_range && seen_q[rd_addr];
		end
		if (done) begin
			rsp_data_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule

// ===== rtl/clw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module clw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/clw_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_update - per-core record update
// Applies one item to the record read from memory and forms the result item.
// ----------------------------------------------------------------------------
module clw_update import clw_pkg::*; (
	input  ctx_t        ctx,
	input  cfg_t        cfg,
	input  entry_t      entry,
	input  logic [31:0] warnings,
	output entry_t      entry_nxt,
	output logic        write,
	output logic [31:0] warnings_nxt,
	output out_item_t   result
);

	logic       core_ok;
	logic [7:0] run_inc;
	status_t    status;
	logic       req;

	// Secondary core below both the slot count and the active count
	assign core_ok = (ctx.item.core != 3'd0) && ctx.in_range
		&& ({1'b0, ctx.item.core} < cfg.active_cores);

	assign run_inc = (entry.frozen_run < RUN_MAX) ? entry.frozen_run + 8'd1 : entry.frozen_run;

	always_comb begin
		entry_nxt    = entry;
		warnings_nxt = warnings;
		status       = ST_IGNORED;
		req          = 1'b0;
		unique case (ctx.item.mode)
			MODE_SAMPLE: begin
				if (core_ok) begin
					if (!entry.seeded || ctx.item.idle_count != entry.last_sample) begin
						entry_nxt.seeded      = 1'b1;
						entry_nxt.last_sample = ctx.item.idle_count;
						entry_nxt.frozen_run  = 8'd0;
						status                = ST_ALIVE;
					end else begin
						entry_nxt.frozen_run = run_inc;
						status               = ST_FROZEN;
						if (run_inc == (cfg.freeze_threshold >> 1)) begin
							warnings_nxt = sat_inc(warnings);
							status       = ST_HALF;
						end
						if (run_inc >= cfg.freeze_threshold) begin
							entry_nxt.online         = 1'b0;
							entry_nxt.last_sample    = 32'd0;
							entry_nxt.frozen_run     = 8'd0;
							entry_nxt.awaiting_power = 1'b1;
							entry_nxt.attempts       = sat_inc(entry.attempts);
							status                   = ST_RECOVER;
							req                      = 1'b1;
						end
					end
				end
			end
			MODE_MANUAL: begin
				if (core_ok) begin
					entry_nxt.online         = 1'b0;
					entry_nxt.last_sample    = 32'd0;
					entry_nxt.frozen_run     = 8'd0;
					entry_nxt.awaiting_power = 1'b1;
					entry_nxt.attempts       = sat_inc(entry.attempts);
					status                   = ST_RECOVER;
					req                      = 1'b1;
				end else begin
					status = ST_INVALID;
				end
			end
			MODE_POWER_ON: begin
				if (core_ok && entry.awaiting_power) begin
					entry_nxt.awaiting_power = 1'b0;
					if (ctx.item.power_code == PWR_SUCCESS) begin
						entry_nxt.online    = 1'b1;
						entry_nxt.successes = sat_inc(entry.successes);
						status              = ST_RECOVERED;
					end else if (ctx.item.power_code == PWR_ALREADY_ON) begin
						entry_nxt.online = 1'b1;
						status           = ST_WEDGE;
					end else begin
						status = ST_FAILED;
					end
				end
			end
			default: begin
				status = ST_IGNORED;
			end
		endcase
	end

	// Only valid cores ever change their record
	assign write = core_ok;

	// Form the result item; cores beyond the slots read as zero
	always_comb begin
		result.status           = status;
		result.event_core       = ctx.item.core;
		result.power_on_request = req;
		result.drain_request    = req;
		result.warning_total    = warnings_nxt;
		if (ctx.in_range) begin
			result.core_online   = entry_nxt.online;
			result.frozen_count  = entry_nxt.frozen_run;
			result.attempt_total = entry_nxt.attempts;
			result.success_total = entry_nxt.successes;
		end else begin
			result.core_online   = 1'b0;
			result.frozen_count  = 8'd0;
			result.attempt_total = 32'd0;
			result.success_total = 32'd0;
		end
	end

endmodule
